// File: rtl/core/bfx_pkg.sv
// ----------------------------------------------------------------------------
// bfx_pkg: shared types and constants of the IR execute unit
// Opcodes, status codes, state machine types and the command record that
// travels from the front part to the back part.
// ----------------------------------------------------------------------------
package bfx_pkg;

   localparam int TAPE_CELLS_DEF = 65536;
   localparam int CELL_BITS_DEF  = 8;
   localparam int PC_BITS_DEF    = 16;

   // Fixed field widths of the item and result formats.
   localparam int FUNC_BITS     = 4;
   localparam int ARG_BITS      = 16;
   localparam int BYTE_BITS     = 8;
   localparam int PTR_BITS      = 16;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;
   localparam int RSP_USER_BITS = 3;

   // The tape index never needs more bits than the pointer has.
   localparam int INDEX_BITS = 16;

   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      OP_ADD    = 4'd1,
      OP_MOVE   = 4'd2,
      OP_JUMP   = 4'd3,
      OP_ADDOFF = 4'd4,
      OP_IN     = 4'd5,
      OP_OUT    = 4'd6,
      OP_CLEAR  = 4'd7,
      OP_END    = 4'd8
   } bfx_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_RUN   = 2'd0,
      ST_ENDED = 2'd1,
      ST_BADOP = 2'd2
   } bfx_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_FOLD,
      F_PUSH
   } bfx_front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_CUR,
      B_TGT
   } bfx_back_state_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [ARG_BITS-1:0]   arg;
      logic [BYTE_BITS-1:0]  in_byte;
      logic [INDEX_BITS-1:0] cur_index;
      logic [INDEX_BITS-1:0] tgt_index;
      logic [PTR_BITS-1:0]   tape_ptr;
   } bfx_cmd_type;

endpackage

// File: rtl/core/bfx_ram.sv
// ----------------------------------------------------------------------------
// bfx_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and returns
// the old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module bfx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/bfx_addr_fold.sv
// ----------------------------------------------------------------------------
// bfx_addr_fold: reduces a 16-bit address modulo the tape size
// Two registered steps: a reciprocal multiply estimates the quotient, then
// the remainder is formed and corrected by one compare and subtract.
// ----------------------------------------------------------------------------
module bfx_addr_fold #(
   parameter int TAPE_CELLS = bfx_pkg::TAPE_CELLS_DEF
) (
   input  logic                            clock,
   input  logic                            en_mul,
   input  logic                            en_sub,
   input  logic [bfx_pkg::PTR_BITS-1:0]    raw,
   output logic [bfx_pkg::INDEX_BITS-1:0]  index
);
   import bfx_pkg::*;

   // floor(2^32 / TAPE_CELLS) fits in 25 bits for at least 256 cells.
   localparam logic [24:0] RECIP = 25'((64'd1 << 32) / TAPE_CELLS);
   localparam logic [17:0] CELLS = 18'(TAPE_CELLS);

   logic [40:0] prod;
   logic [8:0]  q_ff;
   logic [25:0] qn;
   logic [17:0] r_ff;
   logic [17:0] r_in;
   logic [17:0] r_fix;

   // The estimate is low by at most one, so the remainder stays below 2N.
   assign prod = 41'(raw) * 41'(RECIP);
   assign qn   = 26'(q_ff) * 26'(TAPE_CELLS);
   assign r_in = 18'(raw) - qn[17:0];

   always_ff @(posedge clock) begin
      if (en_mul) begin
         q_ff <= prod[40:32];
      end
      if (en_sub) begin
         r_ff <= r_in;
      end
   end

   assign r_fix = (r_ff >= CELLS) ? (r_ff - CELLS) : r_ff;
   assign index = r_fix[INDEX_BITS-1:0];
endmodule

// File: rtl/core/bfx_front.sv
// ----------------------------------------------------------------------------
// bfx_front: instruction intake and pointer tracking
// Accepts items, keeps the tape pointer, folds the current and target
// addresses into tape indexes and pushes commands into the queue.
// ----------------------------------------------------------------------------
module bfx_front #(
   parameter int TAPE_CELLS = bfx_pkg::TAPE_CELLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clr_busy,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bfx_pkg::FUNC_BITS-1:0] req_func,
   input  logic [bfx_pkg::ARG_BITS-1:0]  req_arg,
   input  logic [bfx_pkg::BYTE_BITS-1:0] req_in_byte,
   input  logic                          q_full,
   output logic                          q_push,
   output bfx_pkg::bfx_cmd_type          q_entry
);
   import bfx_pkg::*;

   bfx_front_state_type state_ff, state_in;

   logic [PTR_BITS-1:0]   pointer_ff;
   logic [PTR_BITS-1:0]   ptr_sum;
   logic [FUNC_BITS-1:0]  func_ff;
   logic [ARG_BITS-1:0]   arg_ff;
   logic [BYTE_BITS-1:0]  in_byte_ff;
   logic [PTR_BITS-1:0]   tptr_ff;
   logic [PTR_BITS-1:0]   raw_cur_ff;
   logic [PTR_BITS-1:0]   raw_tgt_ff;
   logic [INDEX_BITS-1:0] cur_index;
   logic [INDEX_BITS-1:0] tgt_index;
   logic                  accept;
   logic                  is_move;
   logic                  en_mul;
   logic                  en_sub;

   assign accept  = req_tvalid && req_tready;
   assign ptr_sum = pointer_ff + req_arg;
   assign is_move = (req_func == OP_MOVE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = F_MUL;
         F_MUL:  state_in = F_FOLD;
         F_FOLD: state_in = F_PUSH;
         F_PUSH: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == F_IDLE) && !clr_busy;
      en_mul     = (state_ff == F_MUL);
      en_sub     = (state_ff == F_FOLD);
      q_push     = (state_ff == F_PUSH) && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         pointer_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && is_move) begin
            pointer_ff <= ptr_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         arg_ff     <= req_arg;
         in_byte_ff <= req_in_byte;
         raw_cur_ff <= pointer_ff;
         raw_tgt_ff <= ptr_sum;
         tptr_ff    <= is_move ? ptr_sum : pointer_ff;
      end
   end

   bfx_addr_fold #(.TAPE_CELLS(TAPE_CELLS)) u_fold_cur (
      .clock  (clock),
      .en_mul (en_mul),
      .en_sub (en_sub),
      .raw    (raw_cur_ff),
      .index  (cur_index)
   );

   bfx_addr_fold #(.TAPE_CELLS(TAPE_CELLS)) u_fold_tgt (
      .clock  (clock),
      .en_mul (en_mul),
      .en_sub (en_sub),
      .raw    (raw_tgt_ff),
      .index  (tgt_index)
   );

   always_comb begin
      q_entry.func      = func_ff;
      q_entry.arg       = arg_ff;
      q_entry.in_byte   = in_byte_ff;
      q_entry.cur_index = cur_index;
      q_entry.tgt_index = tgt_index;
      q_entry.tape_ptr  = tptr_ff;
   end
endmodule

// File: rtl/core/bfx_cmd_queue.sv
// ----------------------------------------------------------------------------
// bfx_cmd_queue: short command FIFO between front and back
// Holds decoded commands so that either side can stall on its own.
// ----------------------------------------------------------------------------
module bfx_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bfx_pkg::bfx_cmd_type push_entry,
   input  logic                 pop,
   output bfx_pkg::bfx_cmd_type head,
   output logic                 empty,
   output logic                 full
);
   import bfx_pkg::*;

   localparam int QAW = $clog2(CMD_QUEUE_DEPTH);
   localparam int CW  = $clog2(CMD_QUEUE_DEPTH + 1);

   bfx_cmd_type      entry_ff [CMD_QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(CMD_QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

// File: rtl/core/bfx_back.sv
// ----------------------------------------------------------------------------
// bfx_back: command execution against the tape
// Runs the clearing pass, reads and writes tape cells, keeps the program
// counter and holds the result register.
// ----------------------------------------------------------------------------
module bfx_back #(
   parameter int TAPE_CELLS = bfx_pkg::TAPE_CELLS_DEF,
   parameter int CELL_BITS  = bfx_pkg::CELL_BITS_DEF,
   parameter int PC_BITS    = bfx_pkg::PC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   output logic                              clr_busy,
   input  bfx_pkg::bfx_cmd_type              head,
   input  logic                              q_empty,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bfx_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [bfx_pkg::RSP_USER_BITS-1:0] rsp_tuser
);
   import bfx_pkg::*;

   localparam int AW = $clog2(TAPE_CELLS);

   bfx_back_state_type state_ff, state_in;

   bfx_cmd_type          cmd_ff;
   logic [CELL_BITS-1:0] cell_ff;
   logic [PC_BITS-1:0]   pc_ff;
   logic                 clr_busy_ff;
   logic [AW-1:0]        clr_addr_ff;

   logic                   rsp_valid_ff;
   logic [PTR_BITS-1:0]    rsp_pc_ff;
   logic [BYTE_BITS-1:0]   rsp_obyte_ff;
   logic                   rsp_oval_ff;
   bfx_status_type         rsp_status_ff;
   logic [PTR_BITS-1:0]    rsp_tptr_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [CELL_BITS-1:0] rd_data;
   logic                 we;
   logic [AW-1:0]        waddr;
   logic [CELL_BITS-1:0] wdata;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [CELL_BITS-1:0] ram_wdata;

   logic                 slot_free;
   logic                 finish;
   logic                 take;
   logic [AW-1:0]        cur_a;
   logic [AW-1:0]        tgt_a;
   logic                 arg_pos;
   logic                 arg_neg;
   logic                 cell_zero;
   logic [PC_BITS-1:0]   res_pc;
   logic                 res_oval;
   logic [BYTE_BITS-1:0] res_obyte;
   bfx_status_type       res_status;

   assign clr_busy  = clr_busy_ff;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cur_a     = cmd_ff.cur_index[AW-1:0];
   assign tgt_a     = cmd_ff.tgt_index[AW-1:0];
   assign arg_neg   = cmd_ff.arg[ARG_BITS-1];
   assign arg_pos   = !arg_neg && (cmd_ff.arg != '0);
   assign cell_zero = (rd_data == '0);

   // Result of the command in cmd_ff; the cell read is valid in B_CUR.
   always_comb begin
      res_pc     = pc_ff + 1'b1;
      res_oval   = 1'b0;
      res_obyte  = '0;
      res_status = ST_RUN;
      unique case (cmd_ff.func)
         OP_ADD, OP_MOVE, OP_ADDOFF, OP_IN, OP_CLEAR: begin
         end
         OP_JUMP: begin
            if ((arg_pos && cell_zero) || (arg_neg && !cell_zero)) begin
               res_pc = pc_ff + PC_BITS'($signed(cmd_ff.arg));
            end
         end
         OP_OUT: begin
            res_oval  = 1'b1;
            res_obyte = rd_data[BYTE_BITS-1:0];
         end
         OP_END: begin
            res_pc     = pc_ff;
            res_status = ST_ENDED;
         end
         default: begin
            res_pc     = pc_ff;
            res_status = ST_BADOP;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!q_empty && !clr_busy_ff) state_in = B_CUR;
         B_CUR: begin
            if (cmd_ff.func == OP_ADDOFF) begin
               state_in = B_TGT;
            end else if (slot_free) begin
               state_in = B_IDLE;
            end
         end
         B_TGT: if (slot_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_a;
      we      = 1'b0;
      waddr   = cur_a;
      wdata   = '0;
      q_pop   = 1'b0;
      take    = 1'b0;
      finish  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty && !clr_busy_ff) begin
               take    = 1'b1;
               q_pop   = 1'b1;
               rd_en   = 1'b1;
               rd_addr = head.cur_index[AW-1:0];
            end
         end
         B_CUR: begin
            if (cmd_ff.func == OP_ADDOFF) begin
               // Read the target while the current cell is cleared.
               rd_en   = 1'b1;
               rd_addr = tgt_a;
               we      = 1'b1;
            end else if (slot_free) begin
               finish = 1'b1;
               unique case (cmd_ff.func)
                  OP_ADD: begin
                     we    = 1'b1;
                     wdata = rd_data + CELL_BITS'($signed(cmd_ff.arg));
                  end
                  OP_IN: begin
                     we    = 1'b1;
                     wdata = CELL_BITS'(cmd_ff.in_byte);
                  end
                  OP_CLEAR: we = 1'b1;
                  default: we = 1'b0;
               endcase
            end
         end
         B_TGT: begin
            if (slot_free) begin
               finish = 1'b1;
               we     = 1'b1;
               waddr  = tgt_a;
               // When the target is the current cell, it must end as zero.
               wdata  = (tgt_a == cur_a) ? '0 : (rd_data + cell_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_we    = clr_busy_ff ? 1'b1 : we;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : waddr;
   assign ram_wdata = clr_busy_ff ? '0 : wdata;

   bfx_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_CELLS), .AW(AW)) u_tape (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pc_ff        <= '0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(TAPE_CELLS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (finish) begin
            pc_ff        <= res_pc;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= head;
      end
      if (state_ff == B_CUR) begin
         cell_ff <= rd_data;
      end
      if (finish) begin
         rsp_pc_ff     <= PTR_BITS'(res_pc);
         rsp_oval_ff   <= res_oval;
         rsp_obyte_ff  <= res_obyte;
         rsp_status_ff <= res_status;
         rsp_tptr_ff   <= cmd_ff.tape_ptr;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tptr_ff, rsp_obyte_ff, rsp_pc_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_oval_ff};
endmodule

// File: rtl/core/bf_ir_execute_unit.sv
// ----------------------------------------------------------------------------
// bf_ir_execute_unit: optimized Brainfuck IR execute unit
// Executes one IR instruction per item against a byte tape, a tape pointer
// and a program counter, and returns one result item per instruction.
// ----------------------------------------------------------------------------
// An item passes the front states F_MUL, F_FOLD and F_PUSH, the queue and the
// back states B_IDLE, B_CUR (and B_TGT for add-at-offset) before rsp_tvalid.
// The front part takes no new item until it has pushed the last one after its
// two-step address fold (reciprocal multiply, then remainder correction).
// Reset: synchronous; afterwards a clearing pass writes zero to all TAPE_CELLS
// cells, one per cycle, and req_tready stays low until the pass is done.
module bf_ir_execute_unit #(
   parameter int TAPE_CELLS = bfx_pkg::TAPE_CELLS_DEF,
   parameter int CELL_BITS  = bfx_pkg::CELL_BITS_DEF,
   parameter int PC_BITS    = bfx_pkg::PC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Instruction items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // func [3:0], arg [19:4], in_byte [27:20], zero padding [31:28]
   input  logic [bfx_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // Result items.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_pc [15:0], out_byte [23:16], tape_pointer [39:24]
   output logic [bfx_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // out_valid [0], status [2:1]
   output logic [bfx_pkg::RSP_USER_BITS-1:0] rsp_tuser
);
   import bfx_pkg::*;

   // Field unpacking of the incoming item.
   logic [FUNC_BITS-1:0] req_func;
   logic [ARG_BITS-1:0]  req_arg;
   logic [BYTE_BITS-1:0] req_in_byte;

   assign req_func    = req_tdata[3:0];
   assign req_arg     = req_tdata[19:4];
   assign req_in_byte = req_tdata[27:20];

   // The front part owns the tape pointer, so pointer moves never wait on
   // the tape. The back part owns the tape and the program counter, since a
   // jump depends on the current cell.
   logic        clr_busy;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   bfx_cmd_type q_entry;
   bfx_cmd_type q_head;

   bfx_front #(.TAPE_CELLS(TAPE_CELLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .clr_busy    (clr_busy),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_func    (req_func),
      .req_arg     (req_arg),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // Commands are queued in order, so every result comes out in item order.
   bfx_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // The back part holds the result register, so the next command can be
   // read from the tape while a finished result still waits for rsp_tready.
   bfx_back #(
      .TAPE_CELLS (TAPE_CELLS),
      .CELL_BITS  (CELL_BITS),
      .PC_BITS    (PC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clr_busy   (clr_busy),
      .head       (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // No item may enter while the tape is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !(req_tvalid && req_tready))
      else $error("item accepted during tape clearing pass");

   // The queue must never be written while it is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("command queue overflow");

   // Only a running instruction can emit an output byte.
   a_out_only_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[2:1] == ST_RUN))
      else $error("output byte flagged on a non-running status");

   // A result that was offered and not taken must hold its flags.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tuser)))
      else $error("stalled result changed");
endmodule
